// ===== rtl/fir_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fir_pkg
// Shared constants, register indexes and control structs for the saturating
// FIR filter and its tap cells.
// ----------------------------------------------------------------------------
package fir_pkg;

   // filter geometry
   localparam int MAX_TAPS       = 64;
   localparam int COEF_FRAC_BITS = 14;

   // field widths
   localparam int SAMPLE_W   = 16;
   localparam int COEF_W     = 16;
   localparam int TAPCNT_W   = 7;
   localparam int INDEX_W    = 6;
   localparam int CSR_ADDR_W = 2;
   localparam int CSR_DATA_W = 16;

   // derived widths
   localparam int FILL_W  = $clog2(MAX_TAPS + 1);
   localparam int STEP_W  = (MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1;
   localparam int CMP_W   = (TAPCNT_W > FILL_W) ? TAPCNT_W : FILL_W;
   localparam int SLOT_W  = (INDEX_W > STEP_W) ? INDEX_W : STEP_W;
   localparam int PROD_W  = SAMPLE_W + COEF_W;
   localparam int ACC_W   = PROD_W + STEP_W;
   localparam int RND_W   = ACC_W + 1 - COEF_FRAC_BITS;

   // register indexes
   localparam logic [CSR_ADDR_W-1:0] CSR_TAP_COUNT  = 2'd0;
   localparam logic [CSR_ADDR_W-1:0] CSR_COEF_INDEX = 2'd1;
   localparam logic [CSR_ADDR_W-1:0] CSR_COEF_VALUE = 2'd2;

   // tap cell controls, common to every cell of the chain
   typedef struct packed {
      logic push;
      logic work_shift;
      logic coef_rotate;
   } cell_ctrl_type;

   // multiply-accumulate controls
   typedef struct packed {
      logic clear;
      logic mul_en;
   } mac_ctrl_type;

endpackage

// ===== rtl/fir_filter_saturating.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fir_filter_saturating
// Direct-form FIR filter over a chain of tap cells, with Q2.14 coefficients,
// half-up rounding and saturation to signed 16 bits.
// ----------------------------------------------------------------------------
//  channel  | ports                                   | transfer
//  ---------+-----------------------------------------+-------------------------
//  req      | req_sample, req_start_req               | req_valid & req_ready
//  rsp      | rsp_filtered, rsp_saturated             | rsp_valid & rsp_ready
//  csr      | csr_index, csr_wdata                    | csr_we, no wait
//
//  a sample that leaves the window short is taken in ST_IDLE and gives no result
//  a sample that fills the window shifts the delay line in ST_IDLE, then goes
//  through ST_RUN, where the coefficient ring walks once round past the single
//  multiplier, ST_ACC, which adds the last product, and ST_DONE, which rounds
//  into the output register; an unread result in the output register stalls
//  the next result in ST_DONE, with req_ready low, until rsp_ready frees it
//  reset is synchronous and clears the delay line, fill count, state and config registers
// ----------------------------------------------------------------------------
module fir_filter_saturating (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  logic signed [fir_pkg::SAMPLE_W-1:0]   req_sample,
   input  logic                                  req_start_req,
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output logic signed [fir_pkg::SAMPLE_W-1:0]   rsp_filtered,
   output logic                                  rsp_saturated,
   input  logic                                  csr_we,
   input  logic [fir_pkg::CSR_ADDR_W-1:0]        csr_index,
   input  logic [fir_pkg::CSR_DATA_W-1:0]        csr_wdata
);
   import fir_pkg::*;

   typedef enum logic [3:0] {
      ST_IDLE = 4'b0001,
      ST_RUN  = 4'b0010,
      ST_ACC  = 4'b0100,
      ST_DONE = 4'b1000
   } state_type;

   state_type                state_ff, state_in;
   logic [TAPCNT_W-1:0]      tap_count_ff;
   logic [INDEX_W-1:0]       coef_index_ff;
   logic [FILL_W-1:0]        fill_ff, fill_in;
   logic [FILL_W-1:0]        fill_base;
   logic [STEP_W-1:0]        step_ff, step_in;
   logic [FILL_W-1:0]        eff_taps;
   logic [CMP_W-1:0]         tap_ext;
   logic [FILL_W-1:0]        lead;
   logic [STEP_W-1:0]        start_step;
   logic                     in_window;
   logic                     accept;
   logic                     window_full;
   logic                     rsp_load;
   logic                     rsp_valid_ff;
   logic signed [SAMPLE_W-1:0] rsp_filtered_ff;
   logic                     rsp_saturated_ff;
   logic signed [SAMPLE_W-1:0] mac_result;
   logic                     mac_sat;
   logic                     coef_write;
   cell_ctrl_type            cell_ctrl;
   mac_ctrl_type             mac_ctrl;

   logic signed [SAMPLE_W-1:0] delay_chain [MAX_TAPS];
   logic signed [SAMPLE_W-1:0] work_chain  [MAX_TAPS];
   logic signed [COEF_W-1:0]   coef_chain  [MAX_TAPS];

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         tap_count_ff  <= TAPCNT_W'(1);
         coef_index_ff <= '0;
      end else if (csr_we) begin
         case (csr_index)
            CSR_TAP_COUNT:  tap_count_ff  <= csr_wdata[TAPCNT_W-1:0];
            CSR_COEF_INDEX: coef_index_ff <= csr_wdata[INDEX_W-1:0];
            default: ;
         endcase
      end
   end

   assign coef_write = csr_we && (csr_index == CSR_COEF_VALUE);

   // effective tap count: zero acts as one, too large acts as the maximum
   assign tap_ext = CMP_W'(tap_count_ff);

   always_comb begin
      if (tap_count_ff == '0) begin
         eff_taps = FILL_W'(1);
      end else if (tap_ext > CMP_W'(MAX_TAPS)) begin
         eff_taps = FILL_W'(MAX_TAPS);
      end else begin
         eff_taps = FILL_W'(tap_ext);
      end
   end

   // products count from the step at which the ring shows coefficient T-1
   assign lead       = FILL_W'(MAX_TAPS) - eff_taps;
   assign start_step = lead[STEP_W-1:0];
   assign in_window  = (state_ff == ST_RUN) && (step_ff >= start_step);

   // fill count after this sample
   assign accept    = req_valid && req_ready;
   assign fill_base = req_start_req ? '0 : fill_ff;

   always_comb begin
      fill_in = fill_ff;
      if (accept) begin
         fill_in = (fill_base < FILL_W'(MAX_TAPS)) ? fill_base + FILL_W'(1) : fill_base;
      end
   end

   assign window_full = (fill_in >= eff_taps);

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff <= '0;
      end else begin
         fill_ff <= fill_in;
      end
   end

   // sequencer
   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_load  = (state_ff == ST_DONE) && (!rsp_valid_ff || rsp_ready);

   always_comb begin
      state_in = state_ff;
      step_in  = step_ff;
      case (state_ff)
         ST_IDLE: begin
            step_in = '0;
            if (accept && window_full) begin
               state_in = ST_RUN;
            end
         end
         ST_RUN: begin
            step_in = step_ff + STEP_W'(1);
            if (step_ff == STEP_W'(MAX_TAPS - 1)) begin
               state_in = ST_ACC;
            end
         end
         ST_ACC: begin
            state_in = ST_DONE;
         end
         ST_DONE: begin
            if (rsp_load) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         step_ff  <= '0;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
      end
   end

   // chain and multiplier controls
   always_comb begin
      cell_ctrl.push        = accept;
      cell_ctrl.work_shift  = in_window;
      cell_ctrl.coef_rotate = (state_ff == ST_RUN);
      mac_ctrl.clear        = accept;
      mac_ctrl.mul_en       = in_window;
   end

   // tap cells: delay line runs up, work copy runs down, coefficient ring rotates up
   assign delay_chain[0] = req_sample;

   for (genvar k = 0; k < MAX_TAPS; k++) begin : g_cell
      localparam int PREV = (k == 0) ? MAX_TAPS - 1 : k - 1;
      logic                        coef_sel;
      logic signed [SAMPLE_W-1:0]  work_next;
      logic signed [SAMPLE_W-1:0]  delay_next;

      assign coef_sel = coef_write && (SLOT_W'(coef_index_ff) == SLOT_W'(k));

      if (k == MAX_TAPS - 1) begin : g_last
         assign work_next = '0;
      end else begin : g_mid
         assign work_next         = work_chain[k + 1];
         assign delay_chain[k + 1] = delay_next;
      end

      fir_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .ctrl       (cell_ctrl),
         .coef_sel   (coef_sel),
         .coef_data  (csr_wdata[COEF_W-1:0]),
         .sample_in  (delay_chain[k]),
         .sample_out (delay_next),
         .work_in    (work_next),
         .work_out   (work_chain[k]),
         .coef_in    (coef_chain[PREV]),
         .coef_out   (coef_chain[k])
      );
   end

   // multiply-accumulate at the chain heads
   fir_mac u_mac (
      .clock      (clock),
      .reset      (reset),
      .ctrl       (mac_ctrl),
      .coef       (coef_chain[MAX_TAPS - 1]),
      .sample     (work_chain[0]),
      .result     (mac_result),
      .result_sat (mac_sat)
   );

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (rsp_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_filtered_ff  <= mac_result;
         rsp_saturated_ff <= mac_sat;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_filtered  = rsp_filtered_ff;
   assign rsp_saturated = rsp_saturated_ff;

endmodule

// ===== rtl/fir_cell.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fir_cell
// One tap cell: a delay-line sample, a working copy of it that walks down to
// the multiplier, and one coefficient slot of the rotating coefficient ring.
// ----------------------------------------------------------------------------
module fir_cell (
   input  logic                                  clock,
   input  logic                                  reset,
   input  fir_pkg::cell_ctrl_type                ctrl,
   input  logic                                  coef_sel,
   input  logic signed [fir_pkg::COEF_W-1:0]     coef_data,
   input  logic signed [fir_pkg::SAMPLE_W-1:0]   sample_in,
   output logic signed [fir_pkg::SAMPLE_W-1:0]   sample_out,
   input  logic signed [fir_pkg::SAMPLE_W-1:0]   work_in,
   output logic signed [fir_pkg::SAMPLE_W-1:0]   work_out,
   input  logic signed [fir_pkg::COEF_W-1:0]     coef_in,
   output logic signed [fir_pkg::COEF_W-1:0]     coef_out
);
   import fir_pkg::*;

   logic signed [SAMPLE_W-1:0] delay_ff;
   logic signed [SAMPLE_W-1:0] work_ff;
   logic signed [SAMPLE_W-1:0] work_in_sel;
   logic signed [COEF_W-1:0]   coef_ff;
   logic signed [COEF_W-1:0]   coef_in_sel;

   // delay line stage, shifts one place per accepted sample
   always_ff @(posedge clock) begin
      if (reset) begin
         delay_ff <= '0;
      end else if (ctrl.push) begin
         delay_ff <= sample_in;
      end
   end

   // working copy: loaded with the new delay value, then walks toward cell 0
   always_comb begin
      work_in_sel = work_ff;
      if (ctrl.push) begin
         work_in_sel = sample_in;
      end else if (ctrl.work_shift) begin
         work_in_sel = work_in;
      end
   end

   always_ff @(posedge clock) begin
      work_ff <= work_in_sel;
   end

   // coefficient slot: written by address, rotated during a pass
   always_comb begin
      coef_in_sel = coef_ff;
      if (coef_sel) begin
         coef_in_sel = coef_data;
      end else if (ctrl.coef_rotate) begin
         coef_in_sel = coef_in;
      end
   end

   always_ff @(posedge clock) begin
      coef_ff <= coef_in_sel;
   end

   assign sample_out = delay_ff;
   assign work_out   = work_ff;
   assign coef_out   = coef_ff;

endmodule

// ===== rtl/fir_mac.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fir_mac
// Multiplier and accumulator at the end of the tap chain, with rounding
// half up and saturation of the finished sum to the sample range.
// ----------------------------------------------------------------------------
module fir_mac (
   input  logic                                  clock,
   input  logic                                  reset,
   input  fir_pkg::mac_ctrl_type                 ctrl,
   input  logic signed [fir_pkg::COEF_W-1:0]     coef,
   input  logic signed [fir_pkg::SAMPLE_W-1:0]   sample,
   output logic signed [fir_pkg::SAMPLE_W-1:0]   result,
   output logic                                  result_sat
);
   import fir_pkg::*;

   localparam logic signed [RND_W-1:0] OUT_MAX = RND_W'((2 ** (SAMPLE_W - 1)) - 1);
   localparam logic signed [RND_W-1:0] OUT_MIN = RND_W'(-(2 ** (SAMPLE_W - 1)));
   localparam logic signed [ACC_W:0]   HALF    = (ACC_W + 1)'(2 ** (COEF_FRAC_BITS - 1));

   logic signed [PROD_W-1:0] prod_ff;
   logic signed [PROD_W-1:0] prod_in;
   logic                     prod_vld_ff;
   logic signed [ACC_W-1:0]  acc_ff;
   logic signed [ACC_W-1:0]  acc_in;
   logic signed [ACC_W:0]    biased;
   logic signed [RND_W-1:0]  rounded;

   // product stage
   assign prod_in = coef * sample;

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prod_vld_ff <= 1'b0;
      end else begin
         prod_vld_ff <= ctrl.mul_en;
      end
   end

   // accumulate stage
   always_comb begin
      acc_in = acc_ff;
      if (ctrl.clear) begin
         acc_in = '0;
      end else if (prod_vld_ff) begin
         acc_in = acc_ff + ACC_W'(prod_ff);
      end
   end

   always_ff @(posedge clock) begin
      acc_ff <= acc_in;
   end

   // round half up, floor by dropping fraction bits, then clamp
   assign biased  = (ACC_W + 1)'(acc_ff) + HALF;
   assign rounded = biased[ACC_W:COEF_FRAC_BITS];

   always_comb begin
      result     = rounded[SAMPLE_W-1:0];
      result_sat = 1'b0;
      if (rounded > OUT_MAX) begin
         result     = OUT_MAX[SAMPLE_W-1:0];
         result_sat = 1'b1;
      end else if (rounded < OUT_MIN) begin
         result     = OUT_MIN[SAMPLE_W-1:0];
         result_sat = 1'b1;
      end
   end

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives samples into the saturating FIR filter through its req channel and
// checks each filtered output against an in-bench filter that keeps its own
// delay line, coefficient table and fill count. The run covers a directed
// set (tap count clamping, saturation at both ends, half-up rounding,
// restart of the window), then random streams under several tap counts,
// coefficient ranges and idle patterns, plus one long receiver hold-off.
// ----------------------------------------------------------------------------
module testbench;
   import fir_pkg::*;

   // spare register index, decoded by nothing in the block
   localparam logic [CSR_ADDR_W-1:0] CSR_SPARE = 2'd3;
   // cycles to let the block settle before touching registers or ending
   localparam int DRAIN_CYCLES = MAX_TAPS + 40;
   localparam int HOLD_CYCLES  = 600;

   typedef enum int {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} idle_mode_type;

   typedef struct {
      logic signed [SAMPLE_W-1:0] filtered;
      logic                       saturated;
   } fir_output_type;

   // expected filter outputs, computed from the samples that were accepted
   class fir_output_board_type;
      logic signed [SAMPLE_W-1:0] history [MAX_TAPS];
      logic signed [COEF_W-1:0]   coefs [MAX_TAPS];
      int unsigned                filled;
      logic [TAPCNT_W-1:0]        tap_reg;
      logic [INDEX_W-1:0]         slot_reg;
      fir_output_type             pending [$];
      int                         errors;

      function new();
         foreach (history[a]) history[a] = '0;
         foreach (coefs[m]) coefs[m] = '0;
         filled   = 0;
         tap_reg  = TAPCNT_W'(1);
         slot_reg = '0;
         errors   = 0;
      endfunction

      function void write_reg(logic [CSR_ADDR_W-1:0] idx, logic [CSR_DATA_W-1:0] data);
         case (idx)
            CSR_TAP_COUNT:  tap_reg = data[TAPCNT_W-1:0];
            CSR_COEF_INDEX: slot_reg = data[INDEX_W-1:0];
            CSR_COEF_VALUE: if (slot_reg < MAX_TAPS) coefs[slot_reg] = data;
            default: ;
         endcase
      endfunction

      // shift the sample in and, once the window is full, work out the output
      function void take_sample(logic signed [SAMPLE_W-1:0] din, logic start);
         int unsigned    taps;
         longint         acc;
         longint         rounded;
         fir_output_type item;
         if (tap_reg == 0) taps = 1;
         else if (tap_reg > MAX_TAPS) taps = MAX_TAPS;
         else taps = int'(tap_reg);
         if (start) filled = 0;
         for (int a = MAX_TAPS - 1; a > 0; a--) history[a] = history[a-1];
         history[0] = din;
         if (filled < MAX_TAPS) filled++;
         if (filled < taps) return;
         // oldest sample in the window meets coefficient 0
         acc = 0;
         for (int m = 0; m < taps; m++)
            acc += longint'(coefs[m]) * longint'(history[taps-1-m]);
         // half toward plus infinity, then clamp to 16 bits
         rounded = (acc + (longint'(1) << (COEF_FRAC_BITS - 1))) >>> COEF_FRAC_BITS;
         item.saturated = 1'b1;
         if (rounded > 32767) rounded = 32767;
         else if (rounded < -32768) rounded = -32768;
         else item.saturated = 1'b0;
         item.filtered = rounded[SAMPLE_W-1:0];
         pending.push_back(item);
      endfunction

      function void check_output(logic signed [SAMPLE_W-1:0] filtered, logic saturated);
         fir_output_type want;
         if (pending.size() == 0) begin
            $error("output with none outstanding: filtered %0d saturated %0b",
                   filtered, saturated);
            errors++;
            return;
         end
         want = pending.pop_front();
         if (filtered !== want.filtered) begin
            $error("filtered: expected %0d, got %0d", want.filtered, filtered);
            errors++;
         end
         if (saturated !== want.saturated) begin
            $error("saturated: expected %0b, got %0b", want.saturated, saturated);
            errors++;
         end
      endfunction

      function int outstanding();
         return pending.size();
      endfunction
   endclass

   logic                          clock = 1'b0;
   logic                          reset = 1'b1;
   logic                          req_valid = 1'b0;
   logic                          req_ready;
   logic signed [SAMPLE_W-1:0]    req_sample = '0;
   logic                          req_start_req = 1'b0;
   logic                          rsp_valid;
   logic                          rsp_ready = 1'b0;
   logic signed [SAMPLE_W-1:0]    rsp_filtered;
   logic                          rsp_saturated;
   logic                          csr_we = 1'b0;
   logic [CSR_ADDR_W-1:0]         csr_index = '0;
   logic [CSR_DATA_W-1:0]         csr_wdata = '0;
   logic                          rsp_hold = 1'b0;

   int                            req_idle_pct = 0;
   int                            rsp_stall_pct = 0;
   fir_output_board_type          board;

   fir_filter_saturating dut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_sample    (req_sample),
      .req_start_req (req_start_req),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_filtered  (rsp_filtered),
      .rsp_saturated (rsp_saturated),
      .csr_we        (csr_we),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata)
   );

   // 10 ns clock
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // receiver: random stalls, and a forced hold-off when asked
   always @(posedge clock) begin
      rsp_ready <= !rsp_hold && ($urandom_range(0, 99) >= rsp_stall_pct);
   end

   // check every output transfer
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) board.check_output(rsp_filtered, rsp_saturated);
   end

   // one register write; csr_we stays high for back-to-back writes
   task automatic csr_write(logic [CSR_ADDR_W-1:0] idx, logic [CSR_DATA_W-1:0] data);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      board.write_reg(idx, data);
   endtask

   task automatic csr_done();
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   // fill every coefficient slot with values in [-span, span]
   task automatic load_coefs(int span);
      int v;
      for (int m = 0; m < MAX_TAPS; m++) begin
         if (span >= 32768 && $urandom_range(0, 15) == 0)
            v = $urandom_range(0, 1) ? 32767 : -32768;
         else
            v = int'($urandom_range(0, 2 * span)) - span;
         if (v > 32767) v = 32767;
         csr_write(CSR_COEF_INDEX, CSR_DATA_W'(m));
         csr_write(CSR_COEF_VALUE, CSR_DATA_W'(v));
      end
   endtask

   // offer one sample and wait for its transfer
   task automatic send_sample(logic signed [SAMPLE_W-1:0] din, logic start);
      while ($urandom_range(0, 99) < req_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_sample    <= din;
      req_start_req <= start;
      do @(posedge clock); while (!req_ready);
      board.take_sample(din, start);
   endtask

   // random stream: mostly plain samples, occasional restarts and extremes
   task automatic send_random(int count, int start_permille);
      logic signed [SAMPLE_W-1:0] din;
      for (int i = 0; i < count; i++) begin
         case ($urandom_range(0, 7))
            0: din = 16'sh7fff;
            1: din = 16'sh8000;
            2: din = SAMPLE_W'(int'($urandom_range(0, 128)) - 64);
            default: din = SAMPLE_W'($urandom);
         endcase
         send_sample(din, $urandom_range(0, 999) < start_permille);
      end
   endtask

   // drop valid, wait for every output, then let the block go quiet
   task automatic drain();
      req_valid <= 1'b0;
      while (board.outstanding() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic set_idle(idle_mode_type mode);
      req_idle_pct  = (mode == IDLE_SEND) ? 52 : (mode == IDLE_BOTH) ? 6 : 0;
      rsp_stall_pct = (mode == IDLE_RECV) ? 52 : (mode == IDLE_BOTH) ? 6 : 0;
   endtask

   task automatic run_phase(int taps, int span, int count, idle_mode_type mode,
                            int start_permille);
      load_coefs(span);
      csr_write(CSR_TAP_COUNT, CSR_DATA_W'(taps));
      csr_done();
      set_idle(mode);
      send_random(count, start_permille);
      drain();
   endtask

   task automatic hold_receiver(int cycles);
      rsp_hold <= 1'b1;
      repeat (cycles) @(posedge clock);
      rsp_hold <= 1'b0;
   endtask

   // watchdog
   initial begin
      #5_000_000;
      $display("== FAIL ==");
      $finish;
   end

   initial begin
      board = new();
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // directed: zero tap count acts as one, coefficient -2.0, both clamps
      load_coefs(0);
      csr_write(CSR_COEF_INDEX, CSR_DATA_W'(0));
      csr_write(CSR_COEF_VALUE, 16'h8000);
      csr_write(CSR_TAP_COUNT, CSR_DATA_W'(0));
      csr_done();
      set_idle(IDLE_NONE);
      send_sample(16'sh7fff, 1'b0);
      send_sample(16'sh8000, 1'b0);
      send_sample(SAMPLE_W'(0), 1'b0);
      send_sample(SAMPLE_W'(1), 1'b0);
      send_sample(SAMPLE_W'(-1), 1'b0);
      send_sample(SAMPLE_W'(123), 1'b1);
      drain();

      // directed: three taps, output is half the oldest sample, so the
      // rounding of exact halves shows; restart leaves the window short
      csr_write(CSR_COEF_INDEX, CSR_DATA_W'(0));
      csr_write(CSR_COEF_VALUE, 16'h2000);
      csr_write(CSR_COEF_INDEX, CSR_DATA_W'(1));
      csr_write(CSR_COEF_VALUE, CSR_DATA_W'(0));
      csr_write(CSR_COEF_INDEX, CSR_DATA_W'(2));
      csr_write(CSR_COEF_VALUE, CSR_DATA_W'(0));
      csr_write(CSR_TAP_COUNT, CSR_DATA_W'(3));
      csr_done();
      send_sample(SAMPLE_W'(1), 1'b1);
      send_sample(SAMPLE_W'(-1), 1'b0);
      send_sample(SAMPLE_W'(3), 1'b0);
      send_sample(SAMPLE_W'(0), 1'b0);
      send_sample(16'sh7fff, 1'b0);
      send_sample(SAMPLE_W'(5), 1'b1);
      send_sample(SAMPLE_W'(5), 1'b0);
      send_sample(SAMPLE_W'(5), 1'b0);
      send_sample(SAMPLE_W'(-3), 1'b0);
      drain();

      // write to the spare index must change nothing
      csr_write(CSR_SPARE, CSR_DATA_W'($urandom));
      csr_done();

      // random phases over tap counts, coefficient ranges and idle patterns
      run_phase(MAX_TAPS, 32768, 200, IDLE_NONE, 3);
      run_phase(127, 2048, 200, IDLE_SEND, 3);
      run_phase(1, 32768, 200, IDLE_RECV, 20);
      run_phase($urandom_range(2, 16), 4096, 200, IDLE_BOTH, 30);

      // long receiver hold-off while samples keep coming
      load_coefs(1024);
      csr_write(CSR_TAP_COUNT, CSR_DATA_W'(8));
      csr_done();
      set_idle(IDLE_NONE);
      fork
         send_random(60, 0);
         hold_receiver(HOLD_CYCLES);
      join
      drain();

      for (int p = 0; p < 2; p++)
         run_phase($urandom_range(0, 127), $urandom_range(0, 32768), 170,
                   idle_mode_type'($urandom_range(0, 3)), 10);

      if (board.errors == 0)
         $display("== PASS ==");
      else
         $display("== FAIL ==");
      $finish;
   end

endmodule
